// ===== sv/asl_pkg.sv =====
// Package: shared types, character codes and constants of the automatic semicolon scanner.
`default_nettype none

package asl_pkg;

	// Default width of the saturating length counter; the port stays 16 bits wide.
	localparam int LENGTH_BITS_DEF = 16;
	localparam int TOKEN_LENGTH_W  = 16;
	localparam int CH_W            = 21;

	// Depth of the queue between the classifier and the scan engine.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Character codes that the classifier looks for.
	localparam logic [CH_W-1:0] CH_NUL    = 21'h00;
	localparam logic [CH_W-1:0] CH_TAB    = 21'h09;
	localparam logic [CH_W-1:0] CH_NL     = 21'h0A;
	localparam logic [CH_W-1:0] CH_VT     = 21'h0B;
	localparam logic [CH_W-1:0] CH_FF     = 21'h0C;
	localparam logic [CH_W-1:0] CH_CR     = 21'h0D;
	localparam logic [CH_W-1:0] CH_SPACE  = 21'h20;
	localparam logic [CH_W-1:0] CH_BANG   = 21'h21;
	localparam logic [CH_W-1:0] CH_PCT    = 21'h25;
	localparam logic [CH_W-1:0] CH_AMP    = 21'h26;
	localparam logic [CH_W-1:0] CH_LPAREN = 21'h28;
	localparam logic [CH_W-1:0] CH_STAR   = 21'h2A;
	localparam logic [CH_W-1:0] CH_PLUS   = 21'h2B;
	localparam logic [CH_W-1:0] CH_COMMA  = 21'h2C;
	localparam logic [CH_W-1:0] CH_MINUS  = 21'h2D;
	localparam logic [CH_W-1:0] CH_DOT    = 21'h2E;
	localparam logic [CH_W-1:0] CH_SLASH  = 21'h2F;
	localparam logic [CH_W-1:0] CH_COLON  = 21'h3A;
	localparam logic [CH_W-1:0] CH_SEMI   = 21'h3B;
	localparam logic [CH_W-1:0] CH_LT     = 21'h3C;
	localparam logic [CH_W-1:0] CH_EQ     = 21'h3D;
	localparam logic [CH_W-1:0] CH_GT     = 21'h3E;
	localparam logic [CH_W-1:0] CH_QMARK  = 21'h3F;
	localparam logic [CH_W-1:0] CH_LBRACK = 21'h5B;
	localparam logic [CH_W-1:0] CH_CARET  = 21'h5E;
	localparam logic [CH_W-1:0] CH_PIPE   = 21'h7C;
	localparam logic [CH_W-1:0] CH_RBRACE = 21'h7D;

	// Token kinds as reported on the result.
	localparam logic [1:0] KIND_SEMI  = 2'd0;
	localparam logic [1:0] KIND_COLON = 2'd1;
	localparam logic [1:0] KIND_PRE   = 2'd2;

	// Input beat.
	typedef struct packed {
		logic            start_req;
		logic            want_preproc;
		logic            want_semicolon;
		logic            want_colon;
		logic [CH_W-1:0] ch;
		logic            range_begin;
	} item_t;

	// Result beat.
	typedef struct packed {
		logic                      done_res;
		logic                      accept;
		logic [1:0]                token_kind;
		logic [TOKEN_LENGTH_W-1:0] token_length;
	} result_t;

	// Character classes; CC_PUNCT covers the continuation marks that need no lookahead.
	typedef enum logic [3:0] {
		CC_ZERO,
		CC_BLANK,
		CC_NL,
		CC_RBRACE,
		CC_COLON,
		CC_QMARK,
		CC_SLASH,
		CC_STAR,
		CC_PLUS,
		CC_MINUS,
		CC_BANG,
		CC_EQ,
		CC_PUNCT,
		CC_OTHER
	} chr_cls_t;

	// Classified item as it travels through the queue.
	typedef struct packed {
		logic     start_req;
		logic     want_preproc;
		logic     want_semicolon;
		logic     want_colon;
		logic     range_begin;
		chr_cls_t cls;
	} cls_item_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_SEMI,
		MODE_COLON,
		MODE_PRE
	} mode_t;

	typedef enum logic [3:0] {
		PH_START,
		PH_WS,
		PH_SLASH,
		PH_LINE,
		PH_BLOCK,
		PH_STAR,
		PH_PLUS,
		PH_MINUS,
		PH_BANG
	} phase_t;

	typedef enum logic [1:0] {
		DEC_NONE,
		DEC_REJECT,
		DEC_ACCEPT
	} dec_t;

endpackage

`default_nettype wire

// ===== sv/asl_front.sv =====
// Front end: takes input beats, classifies the character and pushes into the queue.
`default_nettype none

module asl_front (
	input  wire               item_valid,
	output logic              item_stall,
	input  asl_pkg::item_t    item,
	input  wire               queue_full,
	output logic              push,
	output asl_pkg::cls_item_t push_data
);
	import asl_pkg::*;

	chr_cls_t cls;

	always_comb begin
		unique case (item.ch)
			CH_NUL: cls = CC_ZERO;
			CH_TAB, CH_VT, CH_FF, CH_CR, CH_SPACE: cls = CC_BLANK;
			CH_NL: cls = CC_NL;
			CH_RBRACE: cls = CC_RBRACE;
			CH_COLON: cls = CC_COLON;
			CH_QMARK: cls = CC_QMARK;
			CH_SLASH: cls = CC_SLASH;
			CH_STAR: cls = CC_STAR;
			CH_PLUS: cls = CC_PLUS;
			CH_MINUS: cls = CC_MINUS;
			CH_BANG: cls = CC_BANG;
			CH_EQ: cls = CC_EQ;
			CH_COMMA, CH_DOT, CH_SEMI, CH_PCT, CH_GT, CH_LT, CH_LBRACK,
			CH_LPAREN, CH_CARET, CH_PIPE, CH_AMP: cls = CC_PUNCT;
			default: cls = CC_OTHER;
		endcase
	end

	assign item_stall = queue_full;
	assign push       = item_valid && !queue_full;

	always_comb begin
		push_data.start_req      = item.start_req;
		push_data.want_preproc   = item.want_preproc;
		push_data.want_semicolon = item.want_semicolon;
		push_data.want_colon     = item.want_colon;
		push_data.range_begin    = item.range_begin;
		push_data.cls            = cls;
	end

endmodule

`default_nettype wire

// ===== sv/asl_queue.sv =====
// Short queue of classified characters between the front end and the scan engine.
`default_nettype none

module asl_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  asl_pkg::cls_item_t push_data,
	input  wire                pop,
	output asl_pkg::cls_item_t head,
	output logic               full,
	output logic               empty
);
	import asl_pkg::*;

	cls_item_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue popped while empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue pushed while full");

endmodule

`default_nettype wire

// ===== sv/asl_back.sv =====
// Scan engine: runs the scan state machine on each queued character and holds the result.
`default_nettype none

module asl_back #(
	parameter int LENGTH_BITS = asl_pkg::LENGTH_BITS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  asl_pkg::cls_item_t head,
	input  wire                empty,
	output logic               pop,
	output logic               result_valid,
	input  wire                result_stall,
	output asl_pkg::result_t   result
);
	import asl_pkg::*;

	localparam int CNT_W = (LENGTH_BITS < TOKEN_LENGTH_W) ? LENGTH_BITS : TOKEN_LENGTH_W;

	mode_t            mode_q;
	phase_t           phase_q;
	logic             tail_q;
	logic [CNT_W-1:0] count_q;
	logic             result_valid_q;
	result_t          result_q;

	mode_t            mode_d;
	phase_t           phase_d;
	logic             tail_d;
	logic [CNT_W-1:0] count_d;
	dec_t             dec;
	logic [1:0]       kind;
	logic [CNT_W-1:0] len;
	result_t          result_d;

	mode_t            mode_b;
	phase_t           phase_b;
	logic             tail_b;
	logic [CNT_W-1:0] count_b;
	phase_t           phase_n;
	logic             tail_n;
	logic             consume;
	logic             blank;
	chr_cls_t         cc;

	assign pop = !empty && (!result_valid_q || !result_stall);

	// Next state and decision.
	always_comb begin
		cc      = head.cls;
		blank   = (cc == CC_BLANK) || (cc == CC_NL);
		mode_b  = mode_q;
		phase_b = phase_q;
		tail_b  = tail_q;
		count_b = count_q;
		dec     = DEC_NONE;
		kind    = KIND_SEMI;
		len     = '0;
		consume = 1'b0;

		if (head.start_req) begin
			phase_b = PH_START;
			tail_b  = 1'b0;
			count_b = '0;
			if (head.want_preproc) begin
				mode_b = MODE_PRE;
			end else if (head.want_semicolon && cc != CC_COLON && cc != CC_QMARK) begin
				mode_b = MODE_SEMI;
			end else if (head.want_colon) begin
				mode_b = MODE_COLON;
			end else begin
				mode_b = MODE_IDLE;
				dec    = DEC_REJECT;
			end
		end

		phase_n = phase_b;
		tail_n  = tail_b;

		unique case (mode_b)
			MODE_SEMI: begin
				kind = KIND_SEMI;
				unique case (phase_b)
					PH_START: begin
						if (cc == CC_ZERO || cc == CC_RBRACE || head.range_begin) begin
							dec = DEC_ACCEPT;
						end else if (cc == CC_NL) begin
							phase_n = PH_WS;
						end else if (cc != CC_BLANK) begin
							dec = DEC_REJECT;
						end
					end
					PH_WS: begin
						case (cc) inside
							CC_BLANK, CC_NL: ;
							CC_SLASH: phase_n = PH_SLASH;
							CC_COLON, CC_STAR, CC_QMARK, CC_EQ, CC_PUNCT: dec = DEC_REJECT;
							CC_PLUS: phase_n = PH_PLUS;
							CC_MINUS: phase_n = PH_MINUS;
							CC_BANG: phase_n = PH_BANG;
							default: dec = DEC_ACCEPT;
						endcase
					end
					PH_SLASH: begin
						if (cc == CC_SLASH) begin
							phase_n = PH_LINE;
						end else if (cc == CC_STAR) begin
							phase_n = PH_BLOCK;
						end else begin
							dec = DEC_REJECT;
						end
					end
					PH_LINE: begin
						if (cc == CC_ZERO) begin
							dec = DEC_ACCEPT;
						end else if (cc == CC_NL) begin
							phase_n = PH_WS;
						end
					end
					PH_BLOCK: begin
						if (cc == CC_ZERO) begin
							dec = DEC_ACCEPT;
						end else if (cc == CC_STAR) begin
							phase_n = PH_STAR;
						end
					end
					PH_STAR: begin
						case (cc)
							CC_SLASH: phase_n = PH_WS;
							CC_ZERO: dec = DEC_ACCEPT;
							CC_STAR: phase_n = PH_STAR;
							default: phase_n = PH_BLOCK;
						endcase
					end
					PH_PLUS: dec = (cc == CC_PLUS) ? DEC_ACCEPT : DEC_REJECT;
					PH_MINUS: dec = (cc == CC_MINUS) ? DEC_ACCEPT : DEC_REJECT;
					PH_BANG: dec = (cc == CC_EQ) ? DEC_REJECT : DEC_ACCEPT;
					default: dec = DEC_REJECT;
				endcase
			end
			MODE_COLON: begin
				kind = KIND_COLON;
				len  = count_b;
				if (!tail_b) begin
					if (blank) begin
						consume = 1'b1;
					end else if (cc == CC_COLON) begin
						consume = 1'b1;
						tail_n  = 1'b1;
					end else begin
						dec = DEC_REJECT;
					end
				end else begin
					dec = (cc != CC_COLON) ? DEC_ACCEPT : DEC_REJECT;
				end
			end
			MODE_PRE: begin
				kind = KIND_PRE;
				len  = count_b;
				if (!tail_b) begin
					if (cc == CC_ZERO) begin
						dec = DEC_REJECT;
					end else begin
						consume = 1'b1;
						tail_n  = (cc == CC_NL);
					end
				end else begin
					dec = (cc == CC_NL) ? DEC_ACCEPT : DEC_REJECT;
				end
			end
			default: ;
		endcase

		count_d = (consume && count_b != '1) ? count_b + 1'b1 : count_b;
		if (dec != DEC_NONE) begin
			mode_d  = MODE_IDLE;
			phase_d = PH_START;
			tail_d  = 1'b0;
		end else begin
			mode_d  = mode_b;
			phase_d = phase_n;
			tail_d  = tail_n;
		end
	end

	// Result fields.
	always_comb begin
		result_d.done_res     = (dec != DEC_NONE);
		result_d.accept       = (dec == DEC_ACCEPT);
		result_d.token_kind   = (dec != DEC_NONE) ? kind : KIND_SEMI;
		result_d.token_length = (dec == DEC_ACCEPT) ? TOKEN_LENGTH_W'(len) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_IDLE;
			phase_q        <= PH_START;
			tail_q         <= 1'b0;
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q         <= mode_d;
				phase_q        <= phase_d;
				tail_q         <= tail_d;
				count_q        <= count_d;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.accept |-> result_q.done_res)
		else $error("accept without done");

	a_semi_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.token_kind == KIND_SEMI |-> result_q.token_length == '0)
		else $error("semicolon token with nonzero length");

	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		pop && dec != DEC_NONE |=> mode_q == MODE_IDLE && phase_q == PH_START)
		else $error("scan not back to idle after decision");

	a_count_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pop && mode_b == MODE_SEMI |=> count_q == $past(count_b))
		else $error("length counter moved during semicolon scan");

endmodule

`default_nettype wire

// ===== sv/auto_semicolon_lexer_scan.sv =====
// Top level of the automatic semicolon scanner: classifier, queue and scan engine.
`default_nettype none

// The block takes one character per beat and returns exactly one result beat
// for each, in order. A beat with start_req set opens a new scan request and
// abandons any scan still in progress; its want flags pick a preprocessor
// argument scan first, then an implied semicolon scan (unless the first
// character is a colon or a question mark), then a ternary colon scan. The
// result carries done_res set on the character that settles the decision,
// together with accept, token_kind and token_length; on every other
// character all result fields are zero. token_length saturates at
// 2^LENGTH_BITS-1, and never above 65535. Throughput is one character per
// clock cycle when the result side does not stall: the front end classifies
// the character and writes it into a four-entry queue at the edge that
// accepts it, and the scan engine takes one queued character per cycle
// through a registered state update, so a result beat is offered from the
// output register once its character has left the queue. The result sits
// in that output register, and the queue keeps taking characters while
// that result waits, until it fills.

module auto_semicolon_lexer_scan #(
	parameter int LENGTH_BITS = asl_pkg::LENGTH_BITS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              item_valid,
	output logic             item_stall,
	input  asl_pkg::item_t   item,
	output logic             result_valid,
	input  wire              result_stall,
	output asl_pkg::result_t result
);
	import asl_pkg::*;

	// Handshake between the classifier and the queue.
	logic      push;
	cls_item_t push_data;

	// Queue state seen by both sides.
	logic      queue_full;
	logic      queue_empty;
	cls_item_t queue_head;
	logic      pop;

	// The classifier turns the 21-bit code point into a small class code, so
	// the engine only compares four-bit codes.
	asl_front u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.queue_full (queue_full),
		.push       (push),
		.push_data  (push_data)
	);

	// The queue decouples input acceptance from result back-pressure.
	asl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (queue_head),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	// The engine holds the scan mode, phase and length counter, and the
	// output register of the result channel.
	asl_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (queue_head),
		.empty        (queue_empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire
